// ===== hdl/park_pkg.sv =====
// Shared widths, the quarter-wave sine table and helpers for the Park transform.
package park_pkg;

   // Field widths and table geometry.
   localparam int DATA_WIDTH       = 16;
   localparam int ANGLE_WIDTH      = 16;
   localparam int TABLE_BITS       = 10;
   localparam int SINE_TABLE_DEPTH = 2 ** TABLE_BITS;
   localparam int FRAC_BITS        = DATA_WIDTH - 1;

   // Derived widths.
   localparam int IDX_WIDTH  = TABLE_BITS + 2;
   localparam int ADDR_WIDTH = TABLE_BITS + 1;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int RND_WIDTH  = DATA_WIDTH + 1;
   localparam int SUM_WIDTH  = DATA_WIDTH + 2;

   // Rounding offset and saturation limits.
   localparam logic signed [PROD_WIDTH-1:0] RND_HALF = PROD_WIDTH'(2 ** (FRAC_BITS - 1));
   localparam logic signed [SUM_WIDTH-1:0]  SAT_HI   = SUM_WIDTH'(2 ** FRAC_BITS - 1);
   localparam logic signed [SUM_WIDTH-1:0]  SAT_LO   = SUM_WIDTH'(-(2 ** FRAC_BITS));

   // Table build constants: pi/2 in Q30 and the full-scale amplitude.
   localparam longint PIH_Q30 = 64'sd1686629713;
   localparam longint AMP_VAL = (64'sd1 <<< FRAC_BITS) - 64'sd1;

   // Taylor term divisors (2n)(2n+1) for n = 1 to 12.
   localparam longint TAYLOR_DIV [1:12] = '{
      64'sd6,   64'sd20,  64'sd42,  64'sd72,  64'sd110, 64'sd156,
      64'sd210, 64'sd272, 64'sd342, 64'sd420, 64'sd506, 64'sd600
   };

   // Operands and trig values that travel from the lookup to the rotation.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] alpha;
      logic signed [DATA_WIDTH-1:0] beta;
      logic signed [DATA_WIDTH-1:0] sin_val;
      logic signed [DATA_WIDTH-1:0] cos_val;
   } park_vec_type;

   typedef logic [FRAC_BITS-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   // Sine of x (Q30) by a truncated 13-term Taylor series.
   function automatic longint sin_q30(input longint x);
      longint unsigned ux;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      ux   = longint'(x);
      x2   = (ux * ux) >> 30;
      term = ux;
      sum  = x;
      for (int n = 1; n <= 12; n++) begin
         term = (term * x2) >> 30;
         term = term / TAYLOR_DIV[n];
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      return sum;
   endfunction

   // Quarter-wave table covering [0, pi/2] with both end points.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint          x;
      longint          s;
      longint unsigned e;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x = (PIH_Q30 * longint'(k)) >>> TABLE_BITS;
         s = sin_q30(x);
         e = (longint'(s) * longint'(AMP_VAL) + (64'd1 << 29)) >> 30;
         if (e > longint'(AMP_VAL)) begin
            e = longint'(AMP_VAL);
         end
         rom[k] = e[FRAC_BITS-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Clamp a sum to the signed output range.
   function automatic logic signed [DATA_WIDTH-1:0] saturate(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic signed [SUM_WIDTH-1:0] c;
      c = v;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end
      return c[DATA_WIDTH-1:0];
   endfunction

endpackage

// ===== hdl/park_rom.sv =====
// Dual-read sine table ROM with registered outputs.
module park_rom
   import park_pkg::*;
(
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] sin_addr,
   input  logic [ADDR_WIDTH-1:0] cos_addr,
   output logic [FRAC_BITS-1:0]  sin_mag,
   output logic [FRAC_BITS-1:0]  cos_mag
);

   logic [FRAC_BITS-1:0] sin_mag_ff;
   logic [FRAC_BITS-1:0] cos_mag_ff;

   // Both lookups are read in the same cycle and held while the stage stalls.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         sin_mag_ff <= SINE_ROM[sin_addr];
         cos_mag_ff <= SINE_ROM[cos_addr];
      end
   end

   assign sin_mag = sin_mag_ff;
   assign cos_mag = cos_mag_ff;

endmodule

// ===== hdl/park_sincos.sv =====
// Angle decode, table lookup and quadrant sign for sine and cosine (three stages).
module park_sincos
   import park_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic signed [DATA_WIDTH-1:0]  in_alpha,
   input  logic signed [DATA_WIDTH-1:0]  in_beta,
   input  logic [ANGLE_WIDTH-1:0]        in_angle,
   output logic                          out_valid,
   input  logic                          out_stall,
   output park_vec_type                  out_vec
);

   // Stage registers.
   logic                          s1_valid_ff;
   logic signed [DATA_WIDTH-1:0]  s1_alpha_ff;
   logic signed [DATA_WIDTH-1:0]  s1_beta_ff;
   logic [ADDR_WIDTH-1:0]         s1_sin_addr_ff;
   logic [ADDR_WIDTH-1:0]         s1_cos_addr_ff;
   logic                          s1_sin_neg_ff;
   logic                          s1_cos_neg_ff;

   logic                          s2_valid_ff;
   logic signed [DATA_WIDTH-1:0]  s2_alpha_ff;
   logic signed [DATA_WIDTH-1:0]  s2_beta_ff;
   logic                          s2_sin_neg_ff;
   logic                          s2_cos_neg_ff;
   logic [FRAC_BITS-1:0]          s2_sin_mag;
   logic [FRAC_BITS-1:0]          s2_cos_mag;

   logic                          s3_valid_ff;
   park_vec_type                  s3_vec_ff;

   // Next values.
   logic [IDX_WIDTH+ANGLE_WIDTH-1:0] idx_full;
   logic [IDX_WIDTH-1:0]             idx;
   logic [1:0]                       sin_quad;
   logic [1:0]                       cos_quad;
   logic [ADDR_WIDTH-1:0]            offset;
   logic [ADDR_WIDTH-1:0]            s1_sin_addr_in;
   logic [ADDR_WIDTH-1:0]            s1_cos_addr_in;
   park_vec_type                     s3_vec_in;

   logic s1_ready;
   logic s2_ready;
   logic s3_ready;

   // Per-stage ready lets bubbles collapse while the output is stalled.
   assign s3_ready = !s3_valid_ff || !out_stall;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_stall = !s1_ready;

   // The angle scaled to a table index over the full turn.
   assign idx_full = {in_angle, {IDX_WIDTH{1'b0}}};
   assign idx      = idx_full[IDX_WIDTH+ANGLE_WIDTH-1:ANGLE_WIDTH];
   assign sin_quad = idx[IDX_WIDTH-1:IDX_WIDTH-2];
   assign cos_quad = sin_quad + 2'd1;
   assign offset   = {1'b0, idx[TABLE_BITS-1:0]};

   // Odd quadrants read the table mirrored.
   assign s1_sin_addr_in = sin_quad[0] ? ADDR_WIDTH'(SINE_TABLE_DEPTH) - offset : offset;
   assign s1_cos_addr_in = cos_quad[0] ? ADDR_WIDTH'(SINE_TABLE_DEPTH) - offset : offset;

   // Stage 1: address generation.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_alpha_ff    <= in_alpha;
         s1_beta_ff     <= in_beta;
         s1_sin_addr_ff <= s1_sin_addr_in;
         s1_cos_addr_ff <= s1_cos_addr_in;
         s1_sin_neg_ff  <= sin_quad[1];
         s1_cos_neg_ff  <= cos_quad[1];
      end
   end

   // Stage 2: table read.
   park_rom u_rom (
      .clock    (clock),
      .rd_en    (s2_ready),
      .sin_addr (s1_sin_addr_ff),
      .cos_addr (s1_cos_addr_ff),
      .sin_mag  (s2_sin_mag),
      .cos_mag  (s2_cos_mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_alpha_ff   <= s1_alpha_ff;
         s2_beta_ff    <= s1_beta_ff;
         s2_sin_neg_ff <= s1_sin_neg_ff;
         s2_cos_neg_ff <= s1_cos_neg_ff;
      end
   end

   // Stage 3: sine is negative in quadrants 2 and 3, cosine in quadrants 1 and 2.
   always_comb begin
      s3_vec_in.alpha   = s2_alpha_ff;
      s3_vec_in.beta    = s2_beta_ff;
      s3_vec_in.sin_val = s2_sin_neg_ff ? -signed'({1'b0, s2_sin_mag})
                                        :  signed'({1'b0, s2_sin_mag});
      s3_vec_in.cos_val = s2_cos_neg_ff ? -signed'({1'b0, s2_cos_mag})
                                        :  signed'({1'b0, s2_cos_mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_vec_ff <= s3_vec_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_vec   = s3_vec_ff;

endmodule

// ===== hdl/park_rotate.sv =====
// Rotation by sine and cosine: products, rounding, then sum and saturation (three stages).
module park_rotate
   import park_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  park_vec_type                  in_vec,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic signed [DATA_WIDTH-1:0]  out_d_axis,
   output logic signed [DATA_WIDTH-1:0]  out_q_axis
);

   // Stage 4: four products.
   logic                          s4_valid_ff;
   logic signed [PROD_WIDTH-1:0]  s4_ac_ff;
   logic signed [PROD_WIDTH-1:0]  s4_bs_ff;
   logic signed [PROD_WIDTH-1:0]  s4_bc_ff;
   logic signed [PROD_WIDTH-1:0]  s4_as_ff;

   // Stage 5: rounded products.
   logic                          s5_valid_ff;
   logic signed [RND_WIDTH-1:0]   s5_ac_ff;
   logic signed [RND_WIDTH-1:0]   s5_bs_ff;
   logic signed [RND_WIDTH-1:0]   s5_bc_ff;
   logic signed [RND_WIDTH-1:0]   s5_as_ff;

   // Stage 6: saturated results.
   logic                          s6_valid_ff;
   logic signed [DATA_WIDTH-1:0]  s6_d_ff;
   logic signed [DATA_WIDTH-1:0]  s6_q_ff;

   logic signed [PROD_WIDTH-1:0]  s4_ac_in;
   logic signed [PROD_WIDTH-1:0]  s4_bs_in;
   logic signed [PROD_WIDTH-1:0]  s4_bc_in;
   logic signed [PROD_WIDTH-1:0]  s4_as_in;
   logic signed [PROD_WIDTH-1:0]  ac_biased;
   logic signed [PROD_WIDTH-1:0]  bs_biased;
   logic signed [PROD_WIDTH-1:0]  bc_biased;
   logic signed [PROD_WIDTH-1:0]  as_biased;
   logic signed [PROD_WIDTH-1:0]  ac_shift;
   logic signed [PROD_WIDTH-1:0]  bs_shift;
   logic signed [PROD_WIDTH-1:0]  bc_shift;
   logic signed [PROD_WIDTH-1:0]  as_shift;
   logic signed [SUM_WIDTH-1:0]   d_sum;
   logic signed [SUM_WIDTH-1:0]   q_sum;

   logic s4_ready;
   logic s5_ready;
   logic s6_ready;

   assign s6_ready = !s6_valid_ff || !out_stall;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign in_stall = !s4_ready;

   // Products of the operands with sine and cosine.
   assign s4_ac_in = in_vec.alpha * in_vec.cos_val;
   assign s4_bs_in = in_vec.beta  * in_vec.sin_val;
   assign s4_bc_in = in_vec.beta  * in_vec.cos_val;
   assign s4_as_in = in_vec.alpha * in_vec.sin_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_ac_ff <= s4_ac_in;
         s4_bs_ff <= s4_bs_in;
         s4_bc_ff <= s4_bc_in;
         s4_as_ff <= s4_as_in;
      end
   end

   // Round to nearest with halves going up: add half an LSB, then floor.
   assign ac_biased = s4_ac_ff + RND_HALF;
   assign bs_biased = s4_bs_ff + RND_HALF;
   assign bc_biased = s4_bc_ff + RND_HALF;
   assign as_biased = s4_as_ff + RND_HALF;
   assign ac_shift  = ac_biased >>> FRAC_BITS;
   assign bs_shift  = bs_biased >>> FRAC_BITS;
   assign bc_shift  = bc_biased >>> FRAC_BITS;
   assign as_shift  = as_biased >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (s5_ready) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready) begin
         s5_ac_ff <= signed'(ac_shift[RND_WIDTH-1:0]);
         s5_bs_ff <= signed'(bs_shift[RND_WIDTH-1:0]);
         s5_bc_ff <= signed'(bc_shift[RND_WIDTH-1:0]);
         s5_as_ff <= signed'(as_shift[RND_WIDTH-1:0]);
      end
   end

   // Combine the rounded products and clamp to the output range.
   assign d_sum = SUM_WIDTH'(s5_ac_ff) + SUM_WIDTH'(s5_bs_ff);
   assign q_sum = SUM_WIDTH'(s5_bc_ff) - SUM_WIDTH'(s5_as_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (s6_ready) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s6_ready) begin
         s6_d_ff <= saturate(d_sum);
         s6_q_ff <= saturate(q_sum);
      end
   end

   assign out_valid  = s6_valid_ff;
   assign out_d_axis = s6_d_ff;
   assign out_q_axis = s6_q_ff;

endmodule

// ===== hdl/park_transform_core.sv =====
// Top level of the fixed-point Park transform pipeline.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_alpha, req_beta, req_angle
//   rsp_      out        rsp_valid/rsp_stall  rsp_d_axis, rsp_q_axis
//
// One transaction enters per cycle while req_stall is low. The six stages are:
// address decode, sine table read, quadrant sign, multiply, round, sum and saturate.
// Reset clears every stage valid bit; payload registers are not reset.
// A stall holds only the stages that are full, so empty slots still fill up.
module park_transform_core
   import park_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [DATA_WIDTH-1:0]  req_alpha,
   input  logic signed [DATA_WIDTH-1:0]  req_beta,
   input  logic [ANGLE_WIDTH-1:0]        req_angle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_d_axis,
   output logic signed [DATA_WIDTH-1:0]  rsp_q_axis
);

   logic         mid_valid;
   logic         mid_stall;
   park_vec_type mid_vec;

   // Sine and cosine lookup.
   park_sincos u_sincos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_alpha  (req_alpha),
      .in_beta   (req_beta),
      .in_angle  (req_angle),
      .out_valid (mid_valid),
      .out_stall (mid_stall),
      .out_vec   (mid_vec)
   );

   // Rotation into the rotor frame.
   park_rotate u_rotate (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_stall   (mid_stall),
      .in_vec     (mid_vec),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_d_axis (rsp_d_axis),
      .out_q_axis (rsp_q_axis)
   );

endmodule
